@@ rtl/least_outstanding_arbiter_core_assert.svh @@
// Assertion macros shared by the arbiter RTL.
// Expects clk and rst_n in the including module's scope.
`ifndef LEAST_OUTSTANDING_ARBITER_CORE_ASSERT_SVH
`define LEAST_OUTSTANDING_ARBITER_CORE_ASSERT_SVH

// cond holds at every clock edge out of reset
`define LOA_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("arbiter check failed");

// ante implies cons in the same cycle
`define LOA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arbiter check failed");

// ante implies cons in the next cycle
`define LOA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arbiter check failed");

`endif

@@ rtl/loa_pkg.sv @@
// Shared types and constants for the least-outstanding arbiter.
// Used by loa_ctrl, loa_dp and least_outstanding_arbiter_core.
package loa_pkg;

    localparam int MAX_TARGETS_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TGT_W           = 4;
    localparam int LOAD_W          = 16;
    localparam int CFG_W           = 5;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_SAT   = 2'd1,
        ERR_ZERO  = 2'd2,
        ERR_RANGE = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DUPD,
        ST_CRD,
        ST_CUPD
    } state_t;

    typedef struct packed {
        logic latch;
        logic scan_rd;
        logic disp_upd;
        logic cmpl_upd;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

@@ rtl/least_outstanding_arbiter_core.sv @@
// Top level of the least-outstanding arbiter.
// Depends on loa_pkg, loa_ctrl and loa_dp.
//
// Each word in gives exactly one result word, shown on chosen_target, target_load
// and error_code for a single cycle with done high; the receiver cannot stall and
// must take it then. A word is taken when start is high and busy is low. A dispatch
// reads one counter per cycle from the counter memory, starting at the rotating
// pointer, for all N = target_count counters and then passes ST_LAST and ST_DUPD;
// a completion passes ST_CRD and ST_CUPD. Busy is high through these states, and
// the next word can be taken once it is low again. The result is shown in the first
// cycle that busy is low again. Write target_count through cfg_we/cfg_wdata
// only while idle; 0 is held as 1 and values above MAX_TARGETS as MAX_TARGETS.
module least_outstanding_arbiter_core
#(
    parameter int MAX_TARGETS = loa_pkg::MAX_TARGETS_DEF,
    parameter int COUNT_WIDTH = loa_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [loa_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic                        action,
    input  logic [loa_pkg::TGT_W-1:0]   done_target,
    output logic                        done,
    output logic [loa_pkg::TGT_W-1:0]   chosen_target,
    output logic [loa_pkg::LOAD_W-1:0]  target_load,
    output logic [1:0]                  error_code
);

    loa_pkg::cmd_t cmd;
    loa_pkg::sts_t sts;

    loa_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    loa_dp
    #(
        .MAX_TARGETS (MAX_TARGETS),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done_target   (done_target),
        .cmd           (cmd),
        .sts           (sts),
        .done          (done),
        .chosen_target (chosen_target),
        .target_load   (target_load),
        .error_code    (error_code)
    );

endmodule

@@ rtl/loa_ctrl.sv @@
// Sequencer for the least-outstanding arbiter.
// Depends on loa_pkg; drives loa_dp through cmd_t, reads sts_t.
module loa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          action,
    input  loa_pkg::sts_t sts,
    output loa_pkg::cmd_t cmd,
    output logic          busy
);

    loa_pkg::state_t state_reg;
    loa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= loa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            loa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = action ? loa_pkg::ST_CRD : loa_pkg::ST_SCAN;
                end
            end
            loa_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = loa_pkg::ST_LAST;
                end
            end
            loa_pkg::ST_LAST: state_next = loa_pkg::ST_DUPD;
            loa_pkg::ST_DUPD: state_next = loa_pkg::ST_IDLE;
            loa_pkg::ST_CRD:  state_next = loa_pkg::ST_CUPD;
            loa_pkg::ST_CUPD: state_next = loa_pkg::ST_IDLE;
            default:          state_next = loa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            loa_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            loa_pkg::ST_SCAN: cmd.scan_rd  = 1'b1;
            loa_pkg::ST_DUPD: cmd.disp_upd = 1'b1;
            loa_pkg::ST_CUPD: cmd.cmpl_upd = 1'b1;
            default:          cmd          = '0;
        endcase
    end

endmodule

@@ rtl/loa_dp.sv @@
// Datapath: counter memory, scan compare, pointer and result word.
// Depends on loa_pkg and least_outstanding_arbiter_core_assert.svh.
`include "least_outstanding_arbiter_core_assert.svh"

module loa_dp
#(
    parameter int MAX_TARGETS = loa_pkg::MAX_TARGETS_DEF,
    parameter int COUNT_WIDTH = loa_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [loa_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [loa_pkg::TGT_W-1:0]   done_target,
    input  loa_pkg::cmd_t               cmd,
    output loa_pkg::sts_t               sts,
    output logic                        done,
    output logic [loa_pkg::TGT_W-1:0]   chosen_target,
    output logic [loa_pkg::LOAD_W-1:0]  target_load,
    output logic [1:0]                  error_code
);

    localparam int IDX_W = $clog2(MAX_TARGETS);
    localparam int NW    = $clog2(MAX_TARGETS + 1);
    localparam int CMP_W = NW + loa_pkg::CFG_W;

    logic [COUNT_WIDTH-1:0] mem [MAX_TARGETS];
    logic [MAX_TARGETS-1:0] vld_reg;

    logic [NW-1:0]          n_reg;
    logic [IDX_W-1:0]       ptr_reg;
    logic [IDX_W-1:0]       startp_reg;
    logic [IDX_W-1:0]       scan_reg;
    logic [IDX_W-1:0]       cnt_reg;
    logic [loa_pkg::TGT_W-1:0] done_reg;

    logic                   pv_reg;
    logic                   pfirst_reg;
    logic [IDX_W-1:0]       pidx_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;

    logic [IDX_W-1:0]       best_idx_reg;
    logic [COUNT_WIDTH-1:0] best_load_reg;

    logic                      strb_reg;
    logic [loa_pkg::TGT_W-1:0] chosen_reg;
    logic [COUNT_WIDTH-1:0]    load_reg;
    loa_pkg::err_t             err_reg;

    logic [CMP_W-1:0]       n_ext;
    logic [CMP_W-1:0]       w_ext;
    logic [NW-1:0]          n_next;
    logic [IDX_W-1:0]       start_sel;
    logic [IDX_W-1:0]       scan_next;
    logic [IDX_W-1:0]       ptr_next;
    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] load_eff;
    logic                   best_upd;
    logic                   sat;
    logic                   in_range;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    assign n_ext = CMP_W'(n_reg);
    assign w_ext = CMP_W'(cfg_wdata);

    always_comb
    begin
        if (w_ext == '0)
        begin
            n_next = NW'(1);
        end
        else if (w_ext > CMP_W'(MAX_TARGETS))
        begin
            n_next = NW'(MAX_TARGETS);
        end
        else
        begin
            n_next = NW'(w_ext);
        end
    end

    assign start_sel = (CMP_W'(ptr_reg) < n_ext) ? ptr_reg : '0;
    assign scan_next = (CMP_W'(scan_reg) + CMP_W'(1) >= n_ext) ? '0 : scan_reg + IDX_W'(1);
    assign ptr_next  = (CMP_W'(startp_reg) + CMP_W'(1) >= n_ext) ? '0 : startp_reg + IDX_W'(1);
    assign sts.scan_last = (CMP_W'(cnt_reg) == n_ext - CMP_W'(1));

    assign rd_addr  = cmd.scan_rd ? scan_reg : IDX_W'(done_reg);
    assign load_eff = rd_vld_reg ? rd_data_reg : '0;
    assign best_upd = pv_reg && (pfirst_reg || (load_eff < best_load_reg));
    assign sat      = &best_load_reg;
    assign in_range = CMP_W'(done_reg) < n_ext;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = best_idx_reg;
        wr_data = sat ? best_load_reg : best_load_reg + COUNT_WIDTH'(1);
        if (cmd.disp_upd)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.cmpl_upd && in_range && (load_eff != '0))
        begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(done_reg);
            wr_data = load_eff - COUNT_WIDTH'(1);
        end
    end

    // counter store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            n_reg      <= NW'(1);
            ptr_reg    <= '0;
            pv_reg     <= 1'b0;
            pfirst_reg <= 1'b0;
            strb_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (cfg_we)
            begin
                n_reg   <= n_next;
                ptr_reg <= '0;
            end
            else if (cmd.disp_upd)
            begin
                ptr_reg <= ptr_next;
            end
            pv_reg     <= cmd.scan_rd;
            pfirst_reg <= cmd.scan_rd && (cnt_reg == '0);
            strb_reg   <= cmd.disp_upd || cmd.cmpl_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_vld_reg <= vld_reg[rd_addr];
        pidx_reg   <= scan_reg;
        if (cmd.latch)
        begin
            startp_reg <= start_sel;
            scan_reg   <= start_sel;
            cnt_reg    <= '0;
            done_reg   <= done_target;
        end
        else if (cmd.scan_rd)
        begin
            scan_reg <= scan_next;
            cnt_reg  <= cnt_reg + IDX_W'(1);
        end
        if (best_upd)
        begin
            best_idx_reg  <= pidx_reg;
            best_load_reg <= load_eff;
        end
        if (cmd.disp_upd)
        begin
            chosen_reg <= loa_pkg::TGT_W'(best_idx_reg);
            load_reg   <= wr_data;
            err_reg    <= sat ? loa_pkg::ERR_SAT : loa_pkg::ERR_OK;
        end
        else if (cmd.cmpl_upd)
        begin
            chosen_reg <= done_reg;
            if (!in_range)
            begin
                load_reg <= '0;
                err_reg  <= loa_pkg::ERR_RANGE;
            end
            else if (load_eff == '0)
            begin
                load_reg <= '0;
                err_reg  <= loa_pkg::ERR_ZERO;
            end
            else
            begin
                load_reg <= wr_data;
                err_reg  <= loa_pkg::ERR_OK;
            end
        end
    end

    assign done          = strb_reg;
    assign chosen_target = chosen_reg;
    assign target_load   = loa_pkg::LOAD_W'(load_reg);
    assign error_code    = err_reg;

    `LOA_ASSERT(a_n_range, (n_reg != '0) && (n_ext <= CMP_W'(MAX_TARGETS)))
    `LOA_ASSERT(a_ptr_range, CMP_W'(ptr_reg) < n_ext)
    `LOA_ASSERT_IMPL(a_no_wr_in_scan, cmd.scan_rd, !wr_en)
    `LOA_ASSERT_IMPL(a_sat_full, strb_reg && (err_reg == loa_pkg::ERR_SAT), &load_reg)
    `LOA_ASSERT_NEXT(a_strobe, cmd.disp_upd || cmd.cmpl_upd, strb_reg)

endmodule
